### rtl/qgp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grace-period tracker package
// Shared types and constants of the quiescent grace-period tracker.
// ----------------------------------------------------------------------------
package qgp_pkg;

   localparam int FUNC_WIDTH     = 2;
   localparam int TID_WIDTH      = 3;
   localparam int ACTIVE_WIDTH   = 4;
   localparam int STATUS_WIDTH   = 3;
   localparam int RELEASED_WIDTH = 16;
   localparam int PENDING_WIDTH  = 18;

   localparam logic [ACTIVE_WIDTH-1:0] ACTIVE_RESET = 4'd8;
   localparam logic [ACTIVE_WIDTH-1:0] ROUND_MAX    = 4'd15;
   localparam logic [ACTIVE_WIDTH-1:0] ROUND_ONE    = 4'd1;

   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_QUIESCE = 2'd0,
      FUNC_RETIRE  = 2'd1,
      FUNC_REINIT  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      PHASE_NOT_ENTERED = 2'd0,
      PHASE_ENTERED     = 2'd1,
      PHASE_DONE        = 2'd2
   } phase_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_RELEASED = 3'd0,
      STATUS_WAITING  = 3'd1,
      STATUS_RECORDED = 3'd2,
      STATUS_FULL     = 3'd3,
      STATUS_REINIT   = 3'd4
   } status_type;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0] func;
      logic [TID_WIDTH-1:0]  thread_id;
      logic                  blocking;
   } req_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0]   status;
      logic [RELEASED_WIDTH-1:0] released_count;
      logic [PENDING_WIDTH-1:0]  pending_count;
      logic                      round_closed;
      logic                      retry_now;
   } rsp_type;

endpackage

### rtl/qgp_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request transaction.
// ----------------------------------------------------------------------------
interface qgp_req_if;
   import qgp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [FUNC_WIDTH-1:0] func;
   logic [TID_WIDTH-1:0]  thread_id;
   logic                  blocking;

   modport source (output valid, output func, output thread_id, output blocking,
                   input ready);
   modport sink (input valid, input func, input thread_id, input blocking,
                 output ready);
endinterface

### rtl/qgp_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one response transaction.
// ----------------------------------------------------------------------------
interface qgp_rsp_if;
   import qgp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [STATUS_WIDTH-1:0]   status;
   logic [RELEASED_WIDTH-1:0] released_count;
   logic [PENDING_WIDTH-1:0]  pending_count;
   logic                      round_closed;
   logic                      retry_now;

   modport source (output valid, output status, output released_count,
                   output pending_count, output round_closed, output retry_now,
                   input ready);
   modport sink (input valid, input status, input released_count,
                 input pending_count, input round_closed, input retry_now,
                 output ready);
endinterface

### rtl/qgp_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request register
// Holds one accepted request until the engine takes it.
// ----------------------------------------------------------------------------
module qgp_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  qgp_pkg::req_type in_item,
   input  logic             take,
   output logic             held_valid,
   output qgp_pkg::req_type held_item
);
   import qgp_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff;

   assign in_ready   = !valid_ff || take;
   assign held_valid = valid_ff;
   assign held_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end
endmodule

### rtl/qgp_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grace-period engine
// Per-thread phases and generation counts, round counters, and the
// combinational update that one request transaction causes.
// ----------------------------------------------------------------------------
module qgp_engine #(
   parameter int THREADS     = 8,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [qgp_pkg::ACTIVE_WIDTH-1:0]    csr_wdata,
   input  qgp_pkg::req_type                    item,
   input  logic                                take,
   output qgp_pkg::rsp_type                    result
);
   import qgp_pkg::*;

   localparam int ID_SPACE = 1 << TID_WIDTH;
   localparam int SLOTS    = (THREADS < ID_SPACE) ? THREADS : ID_SPACE;
   localparam int IW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW       = COUNT_WIDTH;
   localparam logic [CW-1:0] COUNT_MAX = '1;

   phase_type              phase_ff  [SLOTS];
   phase_type              phase_in  [SLOTS];
   logic [CW-1:0]          newest_ff [SLOTS];
   logic [CW-1:0]          newest_in [SLOTS];
   logic [CW-1:0]          middle_ff [SLOTS];
   logic [CW-1:0]          middle_in [SLOTS];
   logic [CW-1:0]          oldest_ff [SLOTS];
   logic [CW-1:0]          oldest_in [SLOTS];
   logic [ACTIVE_WIDTH-1:0] active_ff, active_in;
   logic [ACTIVE_WIDTH-1:0] remaining_ff, remaining_in;
   logic [ACTIVE_WIDTH-1:0] entered_ff, entered_in;

   logic                   tid_valid;
   logic                   participant;
   logic [IW-1:0]          idx;
   logic [CW-1:0]          cur_n, cur_m, cur_o;
   logic [CW-1:0]          n_nx, m_nx, o_nx, rel;
   logic [CW:0]            merge_sum;
   logic [CW-1:0]          merge_sat;
   logic [ACTIVE_WIDTH-1:0] entered_inc;
   logic [CW+1:0]          total;
   logic [CW+PENDING_WIDTH+1:0] pending_wide;
   logic [CW+RELEASED_WIDTH-1:0] released_wide;
   status_type             status;
   logic                   closed;
   logic                   retry;

   assign tid_valid   = (int'(item.thread_id) < THREADS);
   assign participant = tid_valid && ({1'b0, item.thread_id} < active_ff);
   assign idx         = tid_valid ? IW'(item.thread_id) : '0;
   assign cur_n       = newest_ff[idx];
   assign cur_m       = middle_ff[idx];
   assign cur_o       = oldest_ff[idx];
   assign merge_sum   = {1'b0, cur_m} + {1'b0, cur_n};
   assign merge_sat   = merge_sum[CW] ? COUNT_MAX : merge_sum[CW-1:0];
   assign entered_inc = (entered_ff < ROUND_MAX) ? entered_ff + ROUND_ONE : entered_ff;

   always_comb begin
      phase_in     = phase_ff;
      newest_in    = newest_ff;
      middle_in    = middle_ff;
      oldest_in    = oldest_ff;
      remaining_in = remaining_ff;
      entered_in   = entered_ff;
      n_nx         = cur_n;
      m_nx         = cur_m;
      o_nx         = cur_o;
      rel          = '0;
      status       = STATUS_WAITING;
      closed       = 1'b0;
      retry        = 1'b0;
      priority if (item.func == FUNC_RETIRE) begin
         if (tid_valid && cur_n != COUNT_MAX) begin
            n_nx   = cur_n + CW'(1);
            status = STATUS_RECORDED;
         end else begin
            status = STATUS_FULL;
         end
      end else if (item.func == FUNC_REINIT) begin
         for (int i = 0; i < SLOTS; i++) begin
            phase_in[i] = PHASE_NOT_ENTERED;
         end
         remaining_in = active_ff;
         entered_in   = '0;
         status       = STATUS_REINIT;
      end else if (item.func == FUNC_QUIESCE && participant) begin
         unique case (phase_ff[idx])
            PHASE_DONE: begin
               rel           = cur_o;
               o_nx          = cur_m;
               m_nx          = '0;
               phase_in[idx] = PHASE_NOT_ENTERED;
               status        = STATUS_RELEASED;
            end
            PHASE_ENTERED: begin
               retry = item.blocking;
            end
            default: begin
               n_nx       = '0;
               entered_in = entered_inc;
               if (remaining_ff <= ROUND_ONE) begin
                  remaining_in = entered_inc;
                  entered_in   = '0;
                  for (int i = 0; i < SLOTS; i++) begin
                     if (i < int'(active_ff)) begin
                        phase_in[i] = PHASE_DONE;
                     end
                  end
                  rel           = cur_o;
                  o_nx          = merge_sat;
                  m_nx          = '0;
                  phase_in[idx] = PHASE_NOT_ENTERED;
                  status        = STATUS_RELEASED;
                  closed        = 1'b1;
               end else begin
                  m_nx          = merge_sat;
                  remaining_in  = remaining_ff - ROUND_ONE;
                  phase_in[idx] = PHASE_ENTERED;
                  retry         = item.blocking;
               end
            end
         endcase
      end else begin
         status = STATUS_WAITING;
      end
      if (tid_valid) begin
         newest_in[idx] = n_nx;
         middle_in[idx] = m_nx;
         oldest_in[idx] = o_nx;
      end
   end

   assign total         = {2'b0, n_nx} + {2'b0, m_nx} + {2'b0, o_nx};
   assign pending_wide  = {{PENDING_WIDTH{1'b0}}, total};
   assign released_wide = {{RELEASED_WIDTH{1'b0}}, rel};

   always_comb begin
      result.status         = status;
      result.released_count = released_wide[RELEASED_WIDTH-1:0];
      result.pending_count  = tid_valid ? pending_wide[PENDING_WIDTH-1:0] : '0;
      result.round_closed   = closed;
      result.retry_now      = retry;
   end

   always_comb begin
      active_in = active_ff;
      if (csr_we) begin
         active_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= ACTIVE_RESET;
         remaining_ff <= ACTIVE_RESET;
         entered_ff   <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            phase_ff[i]  <= PHASE_NOT_ENTERED;
            newest_ff[i] <= '0;
            middle_ff[i] <= '0;
            oldest_ff[i] <= '0;
         end
      end else begin
         active_ff <= active_in;
         if (take) begin
            remaining_ff <= remaining_in;
            entered_ff   <= entered_in;
            phase_ff     <= phase_in;
            newest_ff    <= newest_in;
            middle_ff    <= middle_in;
            oldest_ff    <= oldest_in;
         end
      end
   end
endmodule

### rtl/qgp_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response register
// Holds one finished response until the sink takes it.
// ----------------------------------------------------------------------------
module qgp_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  qgp_pkg::rsp_type load_item,
   output logic             can_load,
   output logic             out_valid,
   input  logic             out_ready,
   output qgp_pkg::rsp_type out_item
);
   import qgp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type item_ff;

   assign can_load  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (can_load) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end
endmodule

### rtl/quiescent_grace_period_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quiescent grace-period tracker
// Counts retired nodes per thread in three generations and runs a fuzzy
// barrier that tells each thread when its oldest generation may be freed.
// ----------------------------------------------------------------------------
// The tracker accepts one request transaction per cycle while the response side
// is not stalled, and returns exactly one response transaction for each. A
// request waits in an input register, the per-thread state and round counters
// update in the cycle in which it leaves that register, and the response is
// held in an output register, so a stalled response does not stop the next
// request from being accepted into the input register. All state is cleared
// directly by reset; no clearing pass is needed. A write of active_threads
// reaches the round counter only at the next reinitialize.
module quiescent_grace_period_tracker_core #(
   parameter int THREADS     = 8,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   qgp_req_if.sink                          req_ch,
   qgp_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [qgp_pkg::ACTIVE_WIDTH-1:0] csr_wdata
);
   import qgp_pkg::*;

   req_type in_item;
   req_type held_item;
   rsp_type result;
   rsp_type out_item;
   logic    held_valid;
   logic    can_load;
   logic    take;

   assign in_item.func      = req_ch.func;
   assign in_item.thread_id = req_ch.thread_id;
   assign in_item.blocking  = req_ch.blocking;
   assign take              = held_valid && can_load;

   qgp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_item    (in_item),
      .take       (take),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   qgp_engine #(
      .THREADS     (THREADS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .item      (held_item),
      .take      (take),
      .result    (result)
   );

   qgp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (take),
      .load_item (result),
      .can_load  (can_load),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_item  (out_item)
   );

   assign rsp_ch.status         = out_item.status;
   assign rsp_ch.released_count = out_item.released_count;
   assign rsp_ch.pending_count  = out_item.pending_count;
   assign rsp_ch.round_closed   = out_item.round_closed;
   assign rsp_ch.retry_now      = out_item.retry_now;
endmodule

### rtl/qgp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grace-period tracker checker
// Port-level checks of the response channel, bound to the tracker core.
// ----------------------------------------------------------------------------
module qgp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [qgp_pkg::STATUS_WIDTH-1:0]   rsp_status,
   input logic [qgp_pkg::RELEASED_WIDTH-1:0] rsp_released_count,
   input logic [qgp_pkg::PENDING_WIDTH-1:0]  rsp_pending_count,
   input logic                               rsp_round_closed,
   input logic                               rsp_retry_now
);
   import qgp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_released_count) && $stable(rsp_pending_count) &&
      $stable(rsp_round_closed) && $stable(rsp_retry_now))
      else $error("Stalled response transaction changed.");

   a_release_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_RELEASED |-> rsp_released_count == '0)
      else $error("Released count is nonzero on a response that releases nothing.");

   a_closed_releases: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_round_closed |-> rsp_status == STATUS_RELEASED)
      else $error("A closing request did not release its thread.");

   a_retry_waiting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_retry_now |-> rsp_status == STATUS_WAITING)
      else $error("Retry requested on a response that is not waiting.");
endmodule

bind quiescent_grace_period_tracker_core qgp_checker u_qgp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_status         (rsp_ch.status),
   .rsp_released_count (rsp_ch.released_count),
   .rsp_pending_count  (rsp_ch.pending_count),
   .rsp_round_closed   (rsp_ch.round_closed),
   .rsp_retry_now      (rsp_ch.retry_now)
);

### bench/quiescent_grace_period_tracker_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grace-period tracker testbench
// Sends request transactions into the tracker with random idle bursts on both
// channels. It predicts each response from its own model of the fuzzy barrier
// and the per-thread generation counts, and checks the responses in order.
// The run covers a directed opening and random traffic under several thread
// counts.
// ----------------------------------------------------------------------------
module quiescent_grace_period_tracker_core_test;
   import qgp_pkg::*;

   localparam int THREADS = 8;
   localparam int SETTLE_CYCLES = 4;
   localparam logic [RELEASED_WIDTH-1:0] COUNT_MAX = 16'hFFFF;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [ACTIVE_WIDTH-1:0] csr_wdata;

   qgp_req_if req_if ();
   qgp_rsp_if rsp_if ();

   quiescent_grace_period_tracker_core #(
      .THREADS    (THREADS),
      .COUNT_WIDTH(16)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_if),
      .rsp_ch   (rsp_if),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   req_type pending_reqs[$];
   rsp_type expected_replies[$];
   int unsigned pushed_total;
   int unsigned accepted_total;
   int unsigned error_count;
   int unsigned req_gap_left;
   int unsigned rsp_stall_left;
   bit idling_on;
   bit req_accepted;

   phase_type thread_phase[THREADS];
   logic [ACTIVE_WIDTH-1:0] active_threads;
   logic [ACTIVE_WIDTH-1:0] round_remaining;
   logic [ACTIVE_WIDTH-1:0] round_entered_next;
   logic [RELEASED_WIDTH-1:0] gen_newest[THREADS];
   logic [RELEASED_WIDTH-1:0] gen_middle[THREADS];
   logic [RELEASED_WIDTH-1:0] gen_oldest[THREADS];

   always #5 clock = ~clock;

   function automatic void restart_barrier();
      foreach (thread_phase[i]) thread_phase[i] = PHASE_NOT_ENTERED;
      round_remaining = active_threads;
      round_entered_next = '0;
   endfunction

   function automatic void clear_tracker_model();
      active_threads = ACTIVE_RESET;
      foreach (gen_newest[i]) begin
         gen_newest[i] = '0;
         gen_middle[i] = '0;
         gen_oldest[i] = '0;
      end
      restart_barrier();
   endfunction

   function automatic logic [RELEASED_WIDTH-1:0] pass_grace_period(input int unsigned t);
      logic [RELEASED_WIDTH-1:0] freed;
      freed = gen_oldest[t];
      thread_phase[t] = PHASE_NOT_ENTERED;
      gen_oldest[t] = gen_middle[t];
      gen_middle[t] = '0;
      return freed;
   endfunction

   task automatic predict_grace_step(input req_type item);
      rsp_type reply;
      int unsigned t;
      logic [RELEASED_WIDTH:0] merged;
      reply = '0;
      reply.status = STATUS_WAITING;
      t = item.thread_id;
      if (item.func == FUNC_RETIRE) begin
         if (gen_newest[t] != COUNT_MAX) begin
            gen_newest[t] = gen_newest[t] + 1'b1;
            reply.status = STATUS_RECORDED;
         end else begin
            reply.status = STATUS_FULL;
         end
      end else if (item.func == FUNC_REINIT) begin
         restart_barrier();
         reply.status = STATUS_REINIT;
      end else if (item.func == FUNC_QUIESCE && t < active_threads) begin
         if (thread_phase[t] == PHASE_DONE) begin
            reply.released_count = pass_grace_period(t);
            reply.status = STATUS_RELEASED;
         end else if (thread_phase[t] == PHASE_ENTERED) begin
            reply.retry_now = item.blocking;
         end else begin
            merged = {1'b0, gen_middle[t]} + {1'b0, gen_newest[t]};
            gen_middle[t] = merged[RELEASED_WIDTH] ? COUNT_MAX : merged[RELEASED_WIDTH-1:0];
            gen_newest[t] = '0;
            if (round_entered_next != ROUND_MAX) round_entered_next++;
            thread_phase[t] = PHASE_ENTERED;
            if (round_remaining <= ROUND_ONE) begin
               round_remaining = round_entered_next;
               round_entered_next = '0;
               for (int i = 0; i < THREADS; i++) begin
                  if (i < active_threads) thread_phase[i] = PHASE_DONE;
               end
               reply.released_count = pass_grace_period(t);
               reply.status = STATUS_RELEASED;
               reply.round_closed = 1'b1;
            end else begin
               round_remaining--;
               reply.retry_now = item.blocking;
            end
         end
      end
      reply.pending_count = PENDING_WIDTH'(gen_newest[t]) + PENDING_WIDTH'(gen_middle[t])
                            + PENDING_WIDTH'(gen_oldest[t]);
      expected_replies.push_back(reply);
   endtask

   task automatic check_reply(input rsp_type got);
      rsp_type want;
      if (expected_replies.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("Unexpected response transaction: status %0d released %0d pending %0d",
                     got.status, got.released_count, got.pending_count);
      end else begin
         want = expected_replies.pop_front();
         if (got.status !== want.status || got.released_count !== want.released_count ||
             got.pending_count !== want.pending_count ||
             got.round_closed !== want.round_closed || got.retry_now !== want.retry_now) begin
            error_count++;
            if (error_count <= 10)
               $display({"Mismatch at %0t: expected status %0d released %0d pending %0d ",
                         "closed %0d retry %0d, got status %0d released %0d pending %0d ",
                         "closed %0d retry %0d"}, $realtime, want.status,
                        want.released_count, want.pending_count, want.round_closed,
                        want.retry_now, got.status, got.released_count, got.pending_count,
                        got.round_closed, got.retry_now);
         end
      end
   endtask

   always @(posedge clock) begin
      req_accepted <= !reset && req_if.valid && req_if.ready;
      if (reset) begin
         clear_tracker_model();
      end else begin
         if (csr_we) active_threads = csr_wdata;
         if (req_if.valid && req_if.ready) begin
            predict_grace_step('{func: req_if.func, thread_id: req_if.thread_id,
                                 blocking: req_if.blocking});
            accepted_total++;
         end
         if (rsp_if.valid && rsp_if.ready)
            check_reply('{status: rsp_if.status, released_count: rsp_if.released_count,
                          pending_count: rsp_if.pending_count,
                          round_closed: rsp_if.round_closed, retry_now: rsp_if.retry_now});
      end
   end

   always @(negedge clock) begin : req_driver
      req_type item;
      if (!reset && (!req_if.valid || req_accepted)) begin
         if (req_gap_left != 0) begin
            req_gap_left--;
            req_if.valid <= 1'b0;
         end else if (pending_reqs.size() == 0) begin
            req_if.valid <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            req_gap_left = $urandom_range(0, 7);
            req_if.valid <= 1'b0;
         end else begin
            item = pending_reqs.pop_front();
            req_if.valid <= 1'b1;
            req_if.func <= item.func;
            req_if.thread_id <= item.thread_id;
            req_if.blocking <= item.blocking;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_stall_left = $urandom_range(0, 7);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic push_req(input func_type f, input logic [TID_WIDTH-1:0] tid,
                           input logic blk);
      pending_reqs.push_back('{func: f, thread_id: tid, blocking: blk});
      pushed_total++;
   endtask

   task automatic drain();
      while (accepted_total != pushed_total || expected_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_active(input logic [ACTIVE_WIDTH-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_traffic(input int unsigned count, input int unsigned active);
      int unsigned roll;
      logic blk;
      for (int unsigned n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         blk = 1'($urandom_range(0, 1));
         if (roll < 48)
            push_req(FUNC_QUIESCE, TID_WIDTH'($urandom_range(0, active - 1)), blk);
         else if (roll < 88)
            push_req(FUNC_RETIRE, TID_WIDTH'($urandom_range(0, active - 1)), blk);
         else if (roll < 93)
            push_req(FUNC_QUIESCE, TID_WIDTH'($urandom_range(0, THREADS - 1)), blk);
         else if (roll < 94)
            push_req(FUNC_REINIT, TID_WIDTH'($urandom_range(0, THREADS - 1)), blk);
         else
            push_req(FUNC_RETIRE, TID_WIDTH'($urandom_range(0, THREADS - 1)), blk);
      end
   endtask

   initial begin
      int unsigned active;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.func = '0;
      req_if.thread_id = '0;
      req_if.blocking = 1'b0;
      rsp_if.ready = 1'b0;
      pushed_total = 0;
      accepted_total = 0;
      error_count = 0;
      req_gap_left = 0;
      rsp_stall_left = 0;
      idling_on = 1'b1;
      req_accepted = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The round counter still holds the reset thread count until the reinitialize.
      write_active(3);
      push_req(FUNC_RETIRE, 0, 0);
      push_req(FUNC_RETIRE, 0, 1);
      push_req(FUNC_RETIRE, 7, 1);
      push_req(FUNC_RETIRE, 2, 0);
      push_req(FUNC_QUIESCE, 7, 1);
      push_req(FUNC_QUIESCE, 1, 1);
      push_req(FUNC_REINIT, 3, 0);
      push_req(FUNC_QUIESCE, 0, 1);
      push_req(FUNC_QUIESCE, 0, 0);
      push_req(FUNC_QUIESCE, 0, 1);
      push_req(FUNC_QUIESCE, 1, 0);
      push_req(FUNC_RETIRE, 2, 1);
      push_req(FUNC_QUIESCE, 2, 1);
      push_req(FUNC_QUIESCE, 0, 0);
      push_req(FUNC_QUIESCE, 1, 1);
      push_req(FUNC_QUIESCE, 2, 0);
      push_req(FUNC_QUIESCE, 0, 1);
      push_req(FUNC_QUIESCE, 1, 0);
      push_req(FUNC_QUIESCE, 0, 1);
      push_req(FUNC_QUIESCE, 2, 0);
      push_req(FUNC_RETIRE, 7, 0);
      push_req(FUNC_QUIESCE, 3, 0);
      drain();

      for (int p = 0; p < 5; p++) begin
         active = (p == 0) ? 1 : (p == 1) ? 8 : $urandom_range(1, 8);
         if (p == 4) idling_on = 1'b0;
         write_active(ACTIVE_WIDTH'(active));
         if ($urandom_range(0, 1))
            push_req(FUNC_REINIT, TID_WIDTH'($urandom_range(0, THREADS - 1)), 0);
         random_traffic(200, active);
         drain();
      end

      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
